// ===== design/shfp_pkg.sv =====
// shared constants, types and the q3.14 multiply for the hull force pipeline
package shfp_pkg;

  // datapath widths
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned ROOT_W = 20;
  localparam int unsigned NUM_W  = 37;
  localparam int unsigned QUO_W  = 17;

  // pipeline depths
  localparam int unsigned SQRT_STAGES = 21;
  localparam int unsigned DIV_STAGES  = QUO_W + 1;
  localparam int unsigned SIDE_DEPTH  = SQRT_STAGES + DIV_STAGES + 1;
  localparam int unsigned TAIL_STAGES = 12;
  localparam int unsigned LATENCY     = 2 + SIDE_DEPTH + TAIL_STAGES + 1;

  // register indexes
  localparam logic [2:0] REG_SURGE_A   = 3'd0;
  localparam logic [2:0] REG_SURGE_SWAY = 3'd1;
  localparam logic [2:0] REG_SWAY_YAW  = 3'd2;
  localparam logic [2:0] REG_YAW_A     = 3'd3;
  localparam logic [2:0] REG_YAW_CUBIC = 3'd4;
  localparam logic [2:0] REG_SCALE     = 3'd5;
  localparam logic [2:0] REG_LENGTH    = 3'd6;

  // q3.14 limit of +-4.0
  localparam logic [QUO_W-1:0] Q14_LIMIT = QUO_W'(65536);

  typedef logic signed [23:0] mono_t;

  // side data that travels beside the root and divider
  typedef struct packed {
    logic              sv;
    logic              sr;
    logic              zero;
    logic [19:0]       va;
    logic [34:0]       nrl;
    logic [SUM_W-1:0]  s;
  } side_t;

  // flags that travel through the back end
  typedef struct packed {
    logic       zero;
    logic       sat;
    logic [2:0] neg;
  } tail_t;

  // q3.14 product, rounded half away from zero
  function automatic mono_t mulq(mono_t a, mono_t b);
    logic [23:0] ma;
    logic [23:0] mb;
    logic [23:0] m;
    logic [47:0] p;
    ma = a[23] ? 24'(-a) : 24'(a);
    mb = b[23] ? 24'(-b) : 24'(b);
    p  = ma * mb + 48'd8192;
    m  = p[37:14];
    return (a[23] ^ b[23]) ? mono_t'(-m) : mono_t'(m);
  endfunction

endpackage

// ===== design/shfp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module shfp_isqrt import shfp_pkg::*; (
  input  logic              clk_i,
  input  logic [SUM_W-1:0]  sum_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned W = 2 * ROOT_W + 2;

  logic [W-1:0] rem_in  [SQRT_STAGES];
  logic [W-1:0] root_in [SQRT_STAGES];
  logic [W-1:0] bit_c   [SQRT_STAGES];
  logic [W-1:0] trial_c [SQRT_STAGES];
  logic [W-1:0] rem_d   [SQRT_STAGES];
  logic [W-1:0] root_d  [SQRT_STAGES];
  logic [W-1:0] rem_q   [SQRT_STAGES];
  logic [W-1:0] root_q  [SQRT_STAGES];

  // stage inputs
  always_comb begin
    rem_in[0]  = W'(sum_i);
    root_in[0] = '0;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
    end
  end

  // one trial subtract per stage
  always_comb begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      bit_c[k]   = W'(1) << (2 * (SQRT_STAGES - 1 - k));
      trial_c[k] = root_in[k] + bit_c[k];
      if (rem_in[k] >= trial_c[k]) begin
        rem_d[k]  = rem_in[k] - trial_c[k];
        root_d[k] = (root_in[k] >> 1) + bit_c[k];
      end else begin
        rem_d[k]  = rem_in[k];
        root_d[k] = root_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ===== design/shfp_div.sv =====
// pipelined rounded divide (2n+u)/(2u), one quotient bit per stage after the first
module shfp_div import shfp_pkg::*; (
  input  logic              clk_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [NUM_W-1:0]  num_i,
  output logic [QUO_W-1:0]  quo_o,
  output logic              ovf_o
);

  localparam int unsigned REM_W = NUM_W + 2;
  localparam int unsigned DEN_W = ROOT_W + 1;

  logic [REM_W-1:0] dsh_c [DIV_STAGES];
  logic [REM_W-1:0] rem_d [DIV_STAGES];
  logic [DEN_W-1:0] den_d [DIV_STAGES];
  logic [QUO_W-1:0] quo_d [DIV_STAGES];
  logic             ovf_d [DIV_STAGES];
  logic [REM_W-1:0] rem_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic             ovf_q [DIV_STAGES];

  // first stage forms the operands and flags a quotient too large
  always_comb begin
    rem_d[0] = REM_W'({num_i, 1'b0}) + REM_W'(root_i);
    den_d[0] = {root_i, 1'b0};
    dsh_c[0] = REM_W'({den_d[0], {QUO_W{1'b0}}});
    ovf_d[0] = rem_d[0] >= dsh_c[0];
    quo_d[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      dsh_c[k] = REM_W'(den_q[k-1]) << (DIV_STAGES - 1 - k);
      den_d[k] = den_q[k-1];
      ovf_d[k] = ovf_q[k-1];
      if (rem_q[k-1] >= dsh_c[k]) begin
        rem_d[k] = rem_q[k-1] - dsh_c[k];
        quo_d[k] = quo_q[k-1] | (QUO_W'(1) << (DIV_STAGES - 1 - k));
      end else begin
        rem_d[k] = rem_q[k-1];
        quo_d[k] = quo_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign quo_o = quo_q[DIV_STAGES-1];
  assign ovf_o = ovf_q[DIV_STAGES-1];

endmodule

// ===== design/ship_hull_force_polynomial.sv =====
// top level of the hull force pipeline: config registers, datapath, flags
//
// Usage: pulse start with a state vector (surge, sway, yaw rate) whenever
// busy is low; busy never rises, so a new vector may enter every cycle.
// Each vector yields one result beat, marked by result_valid_o for one
// cycle. The receiver cannot hold results off and none is needed: the
// pipeline never stalls.
// Throughput is one vector per cycle. The depth is set by the 21 stage
// square root, the two 18 stage dividers that form v/U and r*L/U, and the
// monomial, polynomial and split wide-multiply stages behind them.
// Configuration beats on the cfg channel are always ready and should be
// sent while no vector is in flight; index 7 is ignored.
// Reset clears the in-flight valid bits and all coefficient registers.
// Zero speed gives zero forces with zero_speed_o set; any clipping of
// v', r' or an output on a moving beat sets saturated_o.
module ship_hull_force_polynomial import shfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [19:0] surge_speed_i,
  input  logic signed [19:0] sway_speed_i,
  input  logic signed [19:0] yaw_rate_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [47:0] surge_force_o,
  output logic signed [47:0] sway_force_o,
  output logic signed [55:0] yaw_moment_o,
  output logic               zero_speed_o,
  output logic               saturated_o
);

  localparam int unsigned T0_IDX = LATENCY - 1 - TAIL_STAGES;

  // configuration registers
  logic [63:0]        coef_q [4];
  logic signed [15:0] cubic_q;
  logic [31:0]        scale_q;
  logic [15:0]        len_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        coef_q[k] <= '0;
      end
      cubic_q <= '0;
      scale_q <= '0;
      len_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SURGE_A:    coef_q[0] <= cfg_data_i;
        REG_SURGE_SWAY: coef_q[1] <= cfg_data_i;
        REG_SWAY_YAW:   coef_q[2] <= cfg_data_i;
        REG_YAW_A:      coef_q[3] <= cfg_data_i;
        REG_YAW_CUBIC:  cubic_q   <= cfg_data_i[15:0];
        REG_SCALE:      scale_q   <= cfg_data_i[31:0];
        REG_LENGTH:     len_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the beats
  logic [LATENCY-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
    end
  end

  // input capture
  logic signed [19:0] u_q, v_q, r_q;

  always_ff @(posedge clk_i) begin
    u_q <= surge_speed_i;
    v_q <= sway_speed_i;
    r_q <= yaw_rate_i;
  end

  // magnitudes, squares and r*L
  logic [19:0] ua_c, va_c, ra_c;
  logic [39:0] usq_c, vsq_c;
  logic [35:0] nrl_c;
  logic [39:0] usq_q, vsq_q;
  logic [19:0] va_q;
  logic [34:0] nrl_q;
  logic        sv_q, sr_q;

  always_comb begin
    ua_c  = u_q[19] ? 20'(-u_q) : 20'(u_q);
    va_c  = v_q[19] ? 20'(-v_q) : 20'(v_q);
    ra_c  = r_q[19] ? 20'(-r_q) : 20'(r_q);
    usq_c = ua_c * ua_c;
    vsq_c = va_c * va_c;
    nrl_c = ra_c * len_q;
  end

  always_ff @(posedge clk_i) begin
    usq_q <= usq_c;
    vsq_q <= vsq_c;
    va_q  <= va_c;
    nrl_q <= nrl_c[34:0];
    sv_q  <= v_q[19];
    sr_q  <= r_q[19];
  end

  // side line from the speed sum to the divider outputs
  side_t            side_q [SIDE_DEPTH];
  logic [SUM_W-1:0] s_c;

  assign s_c = usq_q + vsq_q;

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{sv: sv_q, sr: sr_q, zero: (s_c == '0), va: va_q, nrl: nrl_q, s: s_c};
    for (int k = 1; k < SIDE_DEPTH; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // total speed and the two ratios
  logic [ROOT_W-1:0] root_c;
  logic [QUO_W-1:0]  quo_v, quo_r;
  logic              ovf_v, ovf_r;

  shfp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .sum_i  (side_q[0].s),
    .root_o (root_c)
  );

  shfp_div u_div_v (
    .clk_i  (clk_i),
    .root_i (root_c),
    .num_i  (NUM_W'({side_q[SQRT_STAGES].va, 14'b0})),
    .quo_o  (quo_v),
    .ovf_o  (ovf_v)
  );

  shfp_div u_div_r (
    .clk_i  (clk_i),
    .root_i (root_c),
    .num_i  (NUM_W'({side_q[SQRT_STAGES].nrl, 2'b0})),
    .quo_o  (quo_r),
    .ovf_o  (ovf_r)
  );

  // clip to +-4.0, sign, and kf partial products
  side_t            sd_c;
  logic             big_v, big_r;
  logic [QUO_W-1:0] mv_c, mr_c;
  mono_t            vp0_q, rp0_q;
  logic [51:0]      plo_q, phi_q;
  tail_t            tl_q [TAIL_STAGES];

  always_comb begin
    sd_c  = side_q[SIDE_DEPTH-1];
    big_v = ovf_v || (quo_v > Q14_LIMIT);
    big_r = ovf_r || (quo_r > Q14_LIMIT);
    mv_c  = big_v ? Q14_LIMIT : quo_v;
    mr_c  = big_r ? Q14_LIMIT : quo_r;
  end

  always_ff @(posedge clk_i) begin
    vp0_q <= sd_c.sv ? -mono_t'(mv_c) : mono_t'(mv_c);
    rp0_q <= sd_c.sr ? -mono_t'(mr_c) : mono_t'(mr_c);
    plo_q <= scale_q * sd_c.s[19:0];
    phi_q <= scale_q * sd_c.s[39:20];
  end

  // kf and the square terms
  logic [71:0] kfs_c;
  logic [51:0] kf1_q, kf2_q, kf3_q, kf4_q, kf5_q, kf6_q;
  mono_t       vp1_q, rp1_q, vp2_q, rp2_q, vr_q;

  assign kfs_c = 72'(plo_q) + (72'(phi_q) << 20) + (72'(1) << 19);

  always_ff @(posedge clk_i) begin
    kf1_q <= kfs_c[71:20];
    vp1_q <= vp0_q;
    rp1_q <= rp0_q;
    vp2_q <= mulq(vp0_q, vp0_q);
    rp2_q <= mulq(rp0_q, rp0_q);
    vr_q  <= mulq(vp0_q, rp0_q);
  end

  // cubic and quartic terms
  mono_t vp_b_q, rp_b_q, vp2_b_q, rp2_b_q, vr_b_q;
  mono_t vp3_q, vp4_q, rp3_q, v2r_q, vr2_q;

  always_ff @(posedge clk_i) begin
    kf2_q   <= kf1_q;
    vp_b_q  <= vp1_q;
    rp_b_q  <= rp1_q;
    vp2_b_q <= vp2_q;
    rp2_b_q <= rp2_q;
    vr_b_q  <= vr_q;
    vp3_q   <= mulq(vp2_q, vp1_q);
    vp4_q   <= mulq(vp2_q, vp2_q);
    rp3_q   <= mulq(rp2_q, rp1_q);
    v2r_q   <= mulq(vp2_q, rp1_q);
    vr2_q   <= mulq(vp1_q, rp2_q);
  end

  // derivative times monomial, one multiplier per lane
  logic signed [15:0] lane_c [17];
  mono_t              mono_c [17];
  logic signed [39:0] term_q [17];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      lane_c[k] = coef_q[k/4][16*(k%4) +: 16];
    end
    lane_c[16] = cubic_q;
    mono_c[0]  = -24'sd16384;
    mono_c[1]  = vp2_b_q;
    mono_c[2]  = vr_b_q;
    mono_c[3]  = rp2_b_q;
    mono_c[4]  = vp4_q;
    mono_c[5]  = vp_b_q;
    mono_c[6]  = rp_b_q;
    mono_c[7]  = vp3_q;
    mono_c[8]  = v2r_q;
    mono_c[9]  = vr2_q;
    mono_c[10] = rp3_q;
    mono_c[11] = vp_b_q;
    mono_c[12] = rp_b_q;
    mono_c[13] = vp3_q;
    mono_c[14] = v2r_q;
    mono_c[15] = vr2_q;
    mono_c[16] = rp3_q;
  end

  always_ff @(posedge clk_i) begin
    kf3_q <= kf2_q;
    for (int k = 0; k < 17; k++) begin
      term_q[k] <= lane_c[k] * mono_c[k];
    end
  end

  // polynomial sums over two stages
  logic signed [43:0] psum_q [6];
  logic signed [43:0] tot_q  [3];

  always_ff @(posedge clk_i) begin
    kf4_q     <= kf3_q;
    psum_q[0] <= term_q[0] + term_q[1] + term_q[2];
    psum_q[1] <= term_q[3] + term_q[4];
    psum_q[2] <= term_q[5] + term_q[6] + term_q[7];
    psum_q[3] <= term_q[8] + term_q[9] + term_q[10];
    psum_q[4] <= term_q[11] + term_q[12] + term_q[13];
    psum_q[5] <= term_q[14] + term_q[15] + term_q[16];
    kf5_q     <= kf4_q;
    for (int f = 0; f < 3; f++) begin
      tot_q[f] <= psum_q[2*f] + psum_q[2*f+1];
    end
  end

  // magnitudes of x, y, n
  logic [43:0] mag_q [3];

  always_ff @(posedge clk_i) begin
    kf6_q <= kf5_q;
    for (int f = 0; f < 3; f++) begin
      mag_q[f] <= tot_q[f][43] ? 44'(-tot_q[f]) : 44'(tot_q[f]);
    end
  end

  // kf times magnitude, split into 26 by 22 bit partial products
  logic [47:0] pp_q   [3][4];
  logic [95:0] prod_q [3];

  always_ff @(posedge clk_i) begin
    for (int f = 0; f < 3; f++) begin
      pp_q[f][0] <= kf6_q[25:0]  * mag_q[f][21:0];
      pp_q[f][1] <= kf6_q[25:0]  * mag_q[f][43:22];
      pp_q[f][2] <= kf6_q[51:26] * mag_q[f][21:0];
      pp_q[f][3] <= kf6_q[51:26] * mag_q[f][43:22];
    end
    for (int f = 0; f < 3; f++) begin
      prod_q[f] <= 96'(pp_q[f][0]) + (96'(pp_q[f][1]) << 22)
                 + (96'(pp_q[f][2]) << 26) + (96'(pp_q[f][3]) << 48);
    end
  end

  // force rounding and clipping, yaw times length partials
  logic [96:0] frs_c  [2];
  logic [69:0] frr_c  [2];
  logic [69:0] flim_c [2];
  logic        fsat_c [2];
  logic [47:0] fmag9_q [2], fmag10_q [2], fmag11_q [2];
  logic [39:0] yp_q [4];
  logic [111:0] qn_q;

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      frs_c[f]  = 97'(prod_q[f]) + (97'(1) << 26);
      frr_c[f]  = frs_c[f][96:27];
      flim_c[f] = (70'(1) << 47) - (tl_q[8].neg[f] ? 70'(0) : 70'(1));
      fsat_c[f] = frr_c[f] > flim_c[f];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int f = 0; f < 2; f++) begin
      fmag9_q[f]  <= fsat_c[f] ? flim_c[f][47:0] : frr_c[f][47:0];
      fmag10_q[f] <= fmag9_q[f];
      fmag11_q[f] <= fmag10_q[f];
    end
    for (int k = 0; k < 4; k++) begin
      yp_q[k] <= prod_q[2][24*k +: 24] * len_q;
    end
    qn_q <= 112'(yp_q[0]) + (112'(yp_q[1]) << 24)
          + (112'(yp_q[2]) << 48) + (112'(yp_q[3]) << 72);
  end

  // yaw rounding and clipping
  logic [112:0] nrs_c;
  logic [79:0]  nrr_c, nlim_c;
  logic         nsat_c;
  logic [55:0]  ymag_q;

  always_comb begin
    nrs_c  = 113'(qn_q) + (113'(1) << 32);
    nrr_c  = nrs_c[112:33];
    nlim_c = (80'(1) << 55) - (tl_q[10].neg[2] ? 80'(0) : 80'(1));
    nsat_c = nrr_c > nlim_c;
  end

  always_ff @(posedge clk_i) begin
    ymag_q <= nsat_c ? nlim_c[55:0] : nrr_c[55:0];
  end

  // flag line through the back end, signs and clip flags join on the way
  always_ff @(posedge clk_i) begin
    tl_q[0] <= '{zero: sd_c.zero, sat: big_v | big_r, neg: 3'b000};
    for (int k = 1; k < TAIL_STAGES; k++) begin
      if (k != 6 && k != 9 && k != 11) begin
        tl_q[k] <= tl_q[k-1];
      end
    end
    tl_q[6]  <= '{zero: tl_q[5].zero, sat: tl_q[5].sat,
                  neg: {tot_q[2][43], tot_q[1][43], tot_q[0][43]}};
    tl_q[9]  <= '{zero: tl_q[8].zero, sat: tl_q[8].sat | fsat_c[0] | fsat_c[1],
                  neg: tl_q[8].neg};
    tl_q[11] <= '{zero: tl_q[10].zero, sat: tl_q[10].sat | nsat_c,
                  neg: tl_q[10].neg};
  end

  // output register, zero speed forces a clean zero result
  logic signed [47:0] surge_q, sway_q;
  logic signed [55:0] yaw_q;
  logic               zero_q, sat_q;

  always_ff @(posedge clk_i) begin
    if (tl_q[11].zero) begin
      surge_q <= '0;
      sway_q  <= '0;
      yaw_q   <= '0;
      zero_q  <= 1'b1;
      sat_q   <= 1'b0;
    end else begin
      surge_q <= tl_q[11].neg[0] ? -$signed(fmag11_q[0]) : $signed(fmag11_q[0]);
      sway_q  <= tl_q[11].neg[1] ? -$signed(fmag11_q[1]) : $signed(fmag11_q[1]);
      yaw_q   <= tl_q[11].neg[2] ? -$signed(ymag_q) : $signed(ymag_q);
      zero_q  <= 1'b0;
      sat_q   <= tl_q[11].sat;
    end
  end

  assign result_valid_o = vld_q[LATENCY-1];
  assign surge_force_o  = surge_q;
  assign sway_force_o   = sway_q;
  assign yaw_moment_o   = yaw_q;
  assign zero_speed_o   = zero_q;
  assign saturated_o    = sat_q;

`ifndef ASSERT_OFF
  // a zero speed beat carries only zeros and no clip flag
  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && zero_speed_o |->
      surge_force_o == '0 && sway_force_o == '0 && yaw_moment_o == '0 && !saturated_o)
    else $error("zero speed beat carries nonzero payload");

  // clipped ratios stay within +-4.0
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[T0_IDX] |->
      vp0_q <= 24'sd65536 && vp0_q >= -24'sd65536
      && rp0_q <= 24'sd65536 && rp0_q >= -24'sd65536)
    else $error("ratio outside q3.14 limit");

  // a divider overflow at a moving beat must raise the clip flag
  a_ovf_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[T0_IDX-1] && !sd_c.zero && (ovf_v || ovf_r) |=> tl_q[0].sat)
    else $error("divider overflow without clip flag");
`endif

endmodule
